// ===== rtl/ray_box_slab_intersect_assert.svh =====
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_assert
// assertion macros for the ray/box slab intersection block
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_INTERSECT_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_ASSERT_SVH

// implication checked on every edge outside reset
`define RBS_ASSERT_IMPL(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);

// implication checked in the next cycle
`define RBS_ASSERT_NEXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

// ===== rtl/rbs_pkg.sv =====
// ----------------------------------------------------------------------------
// rbs_pkg
// shared types and constants of the ray/box slab intersection block
// ----------------------------------------------------------------------------
package rbs_pkg;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned OutFrac = 16;
  localparam int unsigned OutWidth = 17;
  localparam int unsigned SegScale = 100;
  localparam int unsigned MirrorMul = 56361;
  localparam int unsigned MirrorShift = 16;

  // input transaction
  typedef struct packed {
    logic signed [CoordWidth-1:0] start_x;
    logic signed [CoordWidth-1:0] start_y;
    logic signed [CoordWidth-1:0] start_z;
    logic signed [CoordWidth-1:0] dir_x;
    logic signed [CoordWidth-1:0] dir_y;
    logic signed [CoordWidth-1:0] dir_z;
    logic signed [CoordWidth-1:0] lo_x;
    logic signed [CoordWidth-1:0] lo_y;
    logic signed [CoordWidth-1:0] lo_z;
    logic signed [CoordWidth-1:0] hi_x;
    logic signed [CoordWidth-1:0] hi_y;
    logic signed [CoordWidth-1:0] hi_z;
  } in_item_t;

  // output transaction
  typedef struct packed {
    logic                hit;
    logic [OutWidth-1:0] enter_param;
    logic [OutWidth-1:0] exit_param;
  } out_item_t;

endpackage

// ===== rtl/rbs_div.sv =====
// ----------------------------------------------------------------------------
// rbs_div
// pipelined signed fixed-point divider, one quotient bit per stage,
// quotient toward zero with FRAC_BITS fraction bits, saturated to 32 bits
// ----------------------------------------------------------------------------
module rbs_div #(
  parameter int unsigned NW = 40,
  parameter int unsigned DW = 40,
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned TW = 8
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  input  logic [TW-1:0]        tag_in,
  output logic signed [31:0]   quo,
  output logic [TW-1:0]        tag_out
);
  // integer quotient bits of the 32-bit result
  localparam int unsigned IB = 32 - FRAC_BITS;
  // total quotient bits developed
  localparam int unsigned QB = 32;
  localparam int unsigned RW = DW + 1;
  localparam int unsigned NS = QB + 1;

  // stage registers
  logic [NW-1:0] n_sh [NS];
  logic [RW-1:0] rem [NS];
  logic [DW-1:0] dmag [NS];
  logic [QB-1:0] q [NS];
  logic          ovf [NS];
  logic          neg [NS];
  logic [TW-1:0] tag [NS];

  logic [NW-1:0] n_abs;
  logic [DW-1:0] d_abs;

  // magnitudes of the operands
  always_comb begin
    n_abs = num[NW-1] ? NW'(-num) : NW'(num);
    d_abs = den[DW-1] ? DW'(-den) : DW'(den);
  end

  // stage zero: the numerator carries FRAC_BITS fraction bits already, so the
  // integer part of the quotient reaches 2^(IB-1) when n >= d << 31
  logic [NW+DW-1:0] hi_lim;
  always_comb hi_lim = (NW+DW)'(d_abs) << (IB + FRAC_BITS - 1);

  // top numerator bits go straight into the remainder; they stay below the
  // divisor whenever the quotient does not saturate
  always_ff @(posedge clk) begin
    if (en) begin
      n_sh[0] <= n_abs << (NW - QB);
      rem[0]  <= RW'(n_abs[NW-1:QB]);
      dmag[0] <= d_abs;
      q[0]    <= '0;
      ovf[0]  <= ((NW+DW)'(n_abs) >= hi_lim);
      neg[0]  <= num[NW-1] ^ den[DW-1];
      tag[0]  <= tag_in;
    end
  end

  // restoring division over the low QB numerator bits
  for (genvar s = 0; s < NS - 1; s++) begin : g_st
    logic [RW-1:0] trial;
    logic          bit_in;
    logic [RW:0]   sh;
    always_comb begin
      bit_in = n_sh[s][NW-1];
      sh     = {rem[s], bit_in};
      trial  = RW'(sh - {2'b00, dmag[s]});
    end
    logic          ge;
    always_comb ge = (sh >= {2'b00, dmag[s]});
    always_ff @(posedge clk) begin
      if (en) begin
        n_sh[s+1] <= n_sh[s] << 1;
        rem[s+1]  <= ge ? trial : RW'(sh);
        dmag[s+1] <= dmag[s];
        q[s+1]    <= {q[s][QB-2:0], ge};
        ovf[s+1]  <= ovf[s];
        neg[s+1]  <= neg[s];
        tag[s+1]  <= tag[s];
      end
    end
  end

  // sign and saturation of the final quotient
  always_comb begin
    logic [32:0] mag;
    mag = ovf[NS-1] ? 33'h1_0000_0000 >> 1 : {1'b0, q[NS-1]};
    if (neg[NS-1]) quo = 32'(-mag);
    else if (mag > 33'h0_7FFF_FFFF) quo = 32'h7FFF_FFFF;
    else quo = 32'(mag);
    tag_out = tag[NS-1];
  end

endmodule

// ===== rtl/ray_box_slab_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// segment against axis-aligned box slab test, fully pipelined
// ----------------------------------------------------------------------------
// channel | direction | payload
// in      | input     | in_item_t  (in_valid / in_ready)
// out     | output    | out_item_t (out_valid / out_ready)
// cfg     | input     | mirror_box (cfg_we / cfg_wdata)
//
// one transaction per cycle when the output is not stalled; 38 register
// stages: two setup stages, 33 in each of the six dividers (operand stage
// plus one quotient bit per stage) and three interval stages.
// rst clears the valid bits and the mirror register.
// a stall at the output freezes the whole pipeline; nothing is lost.
module ray_box_slab_intersect #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rbs_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rbs_pkg::out_item_t   out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata
);
  localparam int unsigned COORD_WIDTH = rbs_pkg::CoordWidth;
  localparam int unsigned NW = COORD_WIDTH + 2 + FRAC_BITS;
  localparam int unsigned DW = COORD_WIDTH + 8;
  localparam int unsigned DLAT = 33;
  localparam logic signed [33:0] One = 34'sd1 <<< FRAC_BITS;

  logic mirror_box;
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) mirror_box <= 1'b0;
    else if (cfg_we) mirror_box <= cfg_wdata;
  end

  // stage 1: sign extend, mirror multiply
  logic signed [COORD_WIDTH-1:0] s1 [3], d1 [3], l1 [3], h1 [3];
  logic [COORD_WIDTH+16:0] mlo, mhi;
  logic mlo_n, mhi_n, mir1;
  always_comb begin
    s1[0] = COORD_WIDTH'(in_data.start_x); s1[1] = COORD_WIDTH'(in_data.start_y);
    s1[2] = COORD_WIDTH'(in_data.start_z);
    d1[0] = COORD_WIDTH'(in_data.dir_x); d1[1] = COORD_WIDTH'(in_data.dir_y);
    d1[2] = COORD_WIDTH'(in_data.dir_z);
    l1[0] = COORD_WIDTH'(in_data.lo_x); l1[1] = COORD_WIDTH'(in_data.lo_y);
    l1[2] = COORD_WIDTH'(in_data.lo_z);
    h1[0] = COORD_WIDTH'(in_data.hi_x); h1[1] = COORD_WIDTH'(in_data.hi_y);
    h1[2] = COORD_WIDTH'(in_data.hi_z);
  end

  logic signed [COORD_WIDTH-1:0] s2 [3], d2 [3], l2 [3], h2 [3];
  logic [COORD_WIDTH+16:0] ml2, mh2;
  logic nl2, nh2, mir2, v2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= s1; d2 <= d1; l2 <= l1; h2 <= h1;
      mir2 <= mirror_box;
      nl2 <= l1[2][COORD_WIDTH-1];
      nh2 <= h1[2][COORD_WIDTH-1];
      ml2 <= (COORD_WIDTH+17)'($unsigned(l1[2][COORD_WIDTH-1] ? -l1[2] : l1[2])) *
             (COORD_WIDTH+17)'(rbs_pkg::MirrorMul);
      mh2 <= (COORD_WIDTH+17)'($unsigned(h1[2][COORD_WIDTH-1] ? -h1[2] : h1[2])) *
             (COORD_WIDTH+17)'(rbs_pkg::MirrorMul);
    end
  end
  assign mlo = ml2; assign mhi = mh2;
  assign mlo_n = nl2; assign mhi_n = nh2; assign mir1 = mir2;

  // stage 2: finish mirror, form numerators and scaled direction
  logic signed [COORD_WIDTH+1:0] lz, hz, ml_p, mh_p;
  always_comb begin
    ml_p = (COORD_WIDTH+2)'((mlo + (1 << (rbs_pkg::MirrorShift - 1)))
            >> rbs_pkg::MirrorShift);
    mh_p = (COORD_WIDTH+2)'((mhi + (1 << (rbs_pkg::MirrorShift - 1)))
            >> rbs_pkg::MirrorShift);
    lz = mir1 ? (mlo_n ? ml_p : -ml_p) : (COORD_WIDTH+2)'(l2[2]);
    hz = mir1 ? (mhi_n ? mh_p : -mh_p) : (COORD_WIDTH+2)'(h2[2]);
  end

  logic signed [COORD_WIDTH+2:0] na3 [3], nb3 [3];
  logic signed [DW-1:0] dd3 [3];
  logic signed [COORD_WIDTH+1:0] lo3 [3], hi3 [3], st3 [3];
  logic v3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        lo3[k] <= (k == 2) ? lz : (COORD_WIDTH+2)'(l2[k]);
        hi3[k] <= (k == 2) ? hz : (COORD_WIDTH+2)'(h2[k]);
        st3[k] <= (COORD_WIDTH+2)'(s2[k]);
        na3[k] <= ((k == 2) ? (COORD_WIDTH+3)'(lz) : (COORD_WIDTH+3)'(l2[k]))
                  - (COORD_WIDTH+3)'(s2[k]);
        nb3[k] <= ((k == 2) ? (COORD_WIDTH+3)'(hz) : (COORD_WIDTH+3)'(h2[k]))
                  - (COORD_WIDTH+3)'(s2[k]);
        dd3[k] <= DW'(d2[k]) * DW'(signed'(8'sd100));
      end
    end
  end

  // per-axis zero check and inside test travel with the dividers
  logic [5:0] ax3;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ax3[2*k]   = (dd3[k] == '0);
      ax3[2*k+1] = !(st3[k] < lo3[k] || st3[k] > hi3[k]);
    end
  end

  // six dividers, numerator pre-shifted by FRAC_BITS; zero divisor forced to 1
  // the low-bound divider of an axis carries its zero flag, the high-bound one its inside flag
  logic signed [31:0] qa [3], qb [3];
  logic [0:0] tz [3], ti [3];
  for (genvar k = 0; k < 3; k++) begin : g_ax
    logic signed [DW-1:0] dv;
    assign dv = (dd3[k] == '0) ? DW'(1) : dd3[k];
    rbs_div #(.NW(NW), .DW(DW), .FRAC_BITS(FRAC_BITS), .TW(1)) u_da (
      .clk(clk), .en(en),
      .num(NW'(na3[k]) <<< FRAC_BITS), .den(dv),
      .tag_in(ax3[2*k]), .quo(qa[k]), .tag_out(tz[k]));
    rbs_div #(.NW(NW), .DW(DW), .FRAC_BITS(FRAC_BITS), .TW(1)) u_db (
      .clk(clk), .en(en),
      .num(NW'(nb3[k]) <<< FRAC_BITS), .den(dv),
      .tag_in(ax3[2*k+1]), .quo(qb[k]), .tag_out(ti[k]));
  end

  // valid bit chain alongside the dividers, reset-cleared
  logic [DLAT-1:0] vdiv;
  always_ff @(posedge clk) begin
    if (rst) vdiv <= '0;
    else if (en) vdiv <= {vdiv[DLAT-2:0], v3};
  end

  // three interval stages, one axis each
  logic signed [33:0] tin [4], tout [4];
  logic ok [4];
  logic vi [4];
  logic signed [31:0] qa_d [3][3], qb_d [3][3];
  logic [5:0] ax_d [3];
  assign tin[0] = '0; assign tout[0] = One; assign ok[0] = 1'b1;
  assign vi[0] = vdiv[DLAT-1];
  assign ax_d[0] = {ti[2], tz[2], ti[1], tz[1], ti[0], tz[0]};
  assign qa_d[0] = qa; assign qb_d[0] = qb;
  for (genvar k = 0; k < 3; k++) begin : g_iv
    logic signed [33:0] a, b, ni, no;
    logic ok_n;
    always_comb begin
      a = 34'(qa_d[k][k] < qb_d[k][k] ? qa_d[k][k] : qb_d[k][k]);
      b = 34'(qa_d[k][k] < qb_d[k][k] ? qb_d[k][k] : qa_d[k][k]);
      ni = tin[k]; no = tout[k]; ok_n = ok[k];
      if (ok[k]) begin
        if (ax_d[k][2*k]) ok_n = ax_d[k][2*k+1];
        else if (tin[k] > b || a > tout[k]) ok_n = 1'b0;
        else begin
          if (a > tin[k]) ni = a;
          if (b < tout[k]) no = b;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) vi[k+1] <= 1'b0;
      else if (en) vi[k+1] <= vi[k];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        tin[k+1] <= ni; tout[k+1] <= no; ok[k+1] <= ok_n;
        if (k < 2) begin
          ax_d[k+1] <= ax_d[k]; qa_d[k+1] <= qa_d[k]; qb_d[k+1] <= qb_d[k];
        end
      end
    end
  end

  // output scaling
  logic [rbs_pkg::OutWidth-1:0] eo, xo;
  always_comb begin
    if (FRAC_BITS >= rbs_pkg::OutFrac) begin
      eo = rbs_pkg::OutWidth'(tin[3] >>> (FRAC_BITS - rbs_pkg::OutFrac));
      xo = rbs_pkg::OutWidth'(tout[3] >>> (FRAC_BITS - rbs_pkg::OutFrac));
    end else begin
      eo = rbs_pkg::OutWidth'(tin[3] <<< (rbs_pkg::OutFrac - FRAC_BITS));
      xo = rbs_pkg::OutWidth'(tout[3] <<< (rbs_pkg::OutFrac - FRAC_BITS));
    end
    out_valid = vi[3];
    out_data.hit = ok[3];
    out_data.enter_param = ok[3] ? eo : '0;
    out_data.exit_param = ok[3] ? xo : '0;
  end

`include "ray_box_slab_intersect_assert.svh"
  `RBS_ASSERT_IMPL(a_ready_stall, out_valid && !out_ready, !in_ready, "ready during stall")
  `RBS_ASSERT_IMPL(a_miss_zero, out_valid && !out_data.hit, out_data.enter_param == '0, "miss not zero")
  `RBS_ASSERT_IMPL(a_order, out_valid && out_data.hit, out_data.enter_param <= out_data.exit_param, "enter after exit")

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// ray/box slab intersection testbench: drives ray/box transactions, predicts
// the hit flag and the entry and exit parameters, and checks every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// expected-result store with its own copy of the slab test
class slab_scoreboard;
  rbs_pkg::out_item_t expected_q[$];
  bit mirror;
  int errors;
  int hits;
  int checked;

  // fixed-point quotient toward zero, saturated to 32 bits
  function longint slab_quot(longint num, longint den);
    longint unsigned n, m, q0, r, mag;
    bit neg;
    n = (num < 0) ? -num : num;
    m = (den < 0) ? -den : den;
    q0 = n / m;
    r = n % m;
    neg = (num < 0) != (den < 0);
    if (q0 >= (64'd1 << 15)) begin
      mag = 64'd1 << 31;
    end else begin
      mag = q0 << 16;
      for (int i = 15; i >= 0; i--) begin
        r = r << 1;
        if (r >= m) begin
          r = r - m;
          mag = mag | (64'd1 << i);
        end
      end
    end
    if (neg) return -longint'(mag);
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return longint'(mag);
  endfunction

  // z bound scaled by -0.86
  function longint mirror_bound(longint z);
    longint unsigned mg, p;
    mg = (z < 0) ? -z : z;
    p = (mg * rbs_pkg::MirrorMul + (64'd1 << 15)) >> rbs_pkg::MirrorShift;
    return (z < 0) ? longint'(p) : -longint'(p);
  endfunction

  // note an accepted input transaction
  function void note_ray(rbs_pkg::in_item_t it);
    longint s[3], dv[3], lo[3], hi[3];
    longint t_in, t_out, d, a, b, tmp;
    bit ok;
    rbs_pkg::out_item_t res;
    s[0] = it.start_x; s[1] = it.start_y; s[2] = it.start_z;
    dv[0] = it.dir_x;  dv[1] = it.dir_y;  dv[2] = it.dir_z;
    lo[0] = it.lo_x;   lo[1] = it.lo_y;   lo[2] = it.lo_z;
    hi[0] = it.hi_x;   hi[1] = it.hi_y;   hi[2] = it.hi_z;
    if (mirror) begin
      lo[2] = mirror_bound(lo[2]);
      hi[2] = mirror_bound(hi[2]);
    end
    t_in = 0;
    t_out = 64'd1 << 16;
    ok = 1;
    for (int k = 0; k < 3 && ok; k++) begin
      d = dv[k] * rbs_pkg::SegScale;
      if (d == 0) begin
        ok = !(s[k] < lo[k] || s[k] > hi[k]);
      end else begin
        a = slab_quot(lo[k] - s[k], d);
        b = slab_quot(hi[k] - s[k], d);
        if (a > b) begin
          tmp = a; a = b; b = tmp;
        end
        if (t_in > b || a > t_out) begin
          ok = 0;
        end else begin
          if (a > t_in) t_in = a;
          if (b < t_out) t_out = b;
        end
      end
    end
    res.hit = ok;
    res.enter_param = ok ? t_in[16:0] : '0;
    res.exit_param = ok ? t_out[16:0] : '0;
    expected_q = {expected_q, res};
  endfunction

  // compare a result against the oldest expectation
  function void check_result(rbs_pkg::out_item_t got);
    rbs_pkg::out_item_t exp_r;
    checked++;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result hit=%0d enter=%0d exit=%0d", $realtime,
               got.hit, got.enter_param, got.exit_param);
      errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    if (exp_r.hit) hits++;
    if (got.hit !== exp_r.hit) begin
      $display("%0t: hit mismatch expected %0d actual %0d", $realtime, exp_r.hit, got.hit);
      errors++;
    end
    if (got.enter_param !== exp_r.enter_param) begin
      $display("%0t: enter_param mismatch expected %0d actual %0d", $realtime,
               exp_r.enter_param, got.enter_param);
      errors++;
    end
    if (got.exit_param !== exp_r.exit_param) begin
      $display("%0t: exit_param mismatch expected %0d actual %0d", $realtime,
               exp_r.exit_param, got.exit_param);
      errors++;
    end
  endfunction
endclass

module tb;

  localparam int Unit = 65536;
  localparam int DrainCycles = 300;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  rbs_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  rbs_pkg::out_item_t out_data;
  logic cfg_we = 0;
  logic cfg_wdata = 0;

  int send_idle = 0;
  int recv_idle = 0;
  int sent = 0;
  int recv_count = 0;
  int hold_cnt = 0;
  bit held = 0;
  slab_scoreboard sb = new();

  ray_box_slab_intersect dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // run limit
  initial begin
    #4ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // transaction monitors
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_ray(in_data);
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // receiver with random stalls and one long hold-off
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) recv_count++;
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 0;
    end else if (!held && recv_count >= 1400) begin
      held = 1;
      hold_cnt = 500;
      out_ready <= 0;
    end else begin
      out_ready <= !rst && ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic rbs_pkg::in_item_t make_ray(int sx, int sy, int sz,
                                                 int dx, int dy, int dz,
                                                 int lx, int ly, int lz,
                                                 int hx, int hy, int hz);
    rbs_pkg::in_item_t it;
    it.start_x = sx; it.start_y = sy; it.start_z = sz;
    it.dir_x = dx;   it.dir_y = dy;   it.dir_z = dz;
    it.lo_x = lx;    it.lo_y = ly;    it.lo_z = lz;
    it.hi_x = hx;    it.hi_y = hy;    it.hi_z = hz;
    return it;
  endfunction

  // offer one transaction and wait for acceptance
  task automatic send_ray(rbs_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // structured box/ray near the origin, or pure noise
  task automatic send_random_ray();
    rbs_pkg::in_item_t it;
    int lo[3], hi[3], s[3], d[3], tgt;
    if ($urandom_range(99) < 30) begin
      it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(3) == 0) it.dir_y = 0;
    end else begin
      for (int k = 0; k < 3; k++) begin
        lo[k] = int'($urandom_range(40 * Unit)) - 20 * Unit;
        hi[k] = lo[k] + int'($urandom_range(10 * Unit));
        if ($urandom_range(19) == 0) hi[k] = lo[k] - int'($urandom_range(Unit));
        s[k] = int'($urandom_range(60 * Unit)) - 30 * Unit;
        tgt = lo[k] + int'($urandom_range(0, hi[k] > lo[k] ? hi[k] - lo[k] : 0));
        d[k] = (tgt - s[k]) / int'($urandom_range(30, 150));
        if ($urandom_range(9) == 0) begin
          d[k] = 0;
          if ($urandom_range(1)) s[k] = tgt;
        end
      end
      it = make_ray(s[0], s[1], s[2], d[0], d[1], d[2],
                    lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    end
    send_ray(it);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_mirror(bit v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.mirror = v;
    @(posedge clk);
  endtask

  // unit box directed cases
  task automatic send_directed();
    int m, x;
    m = 32'h8000_0000;
    x = 32'h7FFF_FFFF;
    // straight through the box along x
    send_ray(make_ray(-2 * Unit, 0, 0, 2621, 0, 0, -Unit, -Unit, -Unit, Unit, Unit, Unit));
    // diagonal entry
    send_ray(make_ray(-2 * Unit, -2 * Unit, -2 * Unit, 2621, 2621, 2621,
                      -Unit, -Unit, -Unit, Unit, Unit, Unit));
    // zero direction outside the y slab
    send_ray(make_ray(-2 * Unit, 3 * Unit, 0, 2621, 0, 0, -Unit, -Unit, -Unit, Unit, Unit, Unit));
    // zero direction on the slab boundary
    send_ray(make_ray(-2 * Unit, Unit, -Unit, 2621, 0, 0, -Unit, -Unit, -Unit, Unit, Unit, Unit));
    // start inside, short segment
    send_ray(make_ray(0, 0, 0, 10, -10, 5, -Unit, -Unit, -Unit, Unit, Unit, Unit));
    // box behind the start
    send_ray(make_ray(5 * Unit, 0, 0, 2621, 0, 0, -Unit, -Unit, -Unit, Unit, Unit, Unit));
    // segment stops short
    send_ray(make_ray(-9 * Unit, 0, 0, 100, 0, 0, -Unit, -Unit, -Unit, Unit, Unit, Unit));
    // reversed bounds with zero direction
    send_ray(make_ray(0, 0, 0, 100, 0, 0, -Unit, Unit, -Unit, Unit, -Unit, Unit));
    // reversed bounds with nonzero direction
    send_ray(make_ray(0, 0, 0, 100, 100, 100, Unit, Unit, Unit, -Unit, -Unit, -Unit));
    // quotient saturation
    send_ray(make_ray(m, 0, 0, 1, 0, 0, x, -Unit, -Unit, x, Unit, Unit));
    send_ray(make_ray(x, 0, 0, -1, 0, 0, m, -Unit, -Unit, m, Unit, Unit));
    // all-field extremes
    send_ray(make_ray(x, x, x, x, x, x, x, x, x, x, x, x));
    send_ray(make_ray(m, m, m, m, m, m, m, m, m, m, m, m));
    send_ray(make_ray(m, x, m, x, m, x, m, m, m, x, x, x));
    send_ray(make_ray(0, 0, 0, 0, 0, 0, m, m, m, x, x, x));
    send_ray(make_ray(x, m, 0, m, x, -1, m, m, m, x, x, x));
    // z box that only hits when mirrored
    send_ray(make_ray(0, 0, -Unit, 0, 0, 1000, -Unit, -Unit, Unit, Unit, Unit, 2 * Unit));
    send_ray(make_ray(0, 0, Unit, 0, 0, 0, -Unit, -Unit, -2 * Unit, Unit, Unit, -Unit));
    send_ray(make_ray(0, 0, 0, 0, 0, 0, -Unit, -Unit, m, Unit, Unit, x));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // phase 1: mirror off, receiver mostly stalled
    set_mirror(0);
    send_idle = 9;
    recv_idle = 73;
    send_directed();
    repeat (560) send_random_ray();
    drain();

    // phase 2: mirror on, sender mostly idle
    set_mirror(1);
    send_idle = 73;
    recv_idle = 9;
    send_directed();
    repeat (560) send_random_ray();
    drain();

    // phase 3: mirror off, full rate with one long output hold-off
    set_mirror(0);
    send_idle = 0;
    recv_idle = 0;
    repeat (590) send_random_ray();
    drain();

    $display("sent %0d ray/box transactions over both mirror settings", sent);
    $display("checked %0d results, %0d hits, one long output hold-off", sb.checked, sb.hits);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rbs_pkg.sv
rtl/rbs_div.sv
rtl/ray_box_slab_intersect.sv
tb/sv/tb.sv
